// File: rtl/tcpbdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpbdp_pkg
// Shared types and constants of the BDP congestion window block.
// ----------------------------------------------------------------------------
package tcpbdp_pkg;

    localparam logic [1:0] ACT_ACK  = 2'd0;
    localparam logic [1:0] ACT_CONG = 2'd1;
    localparam logic [1:0] ACT_LOSS = 2'd2;
    localparam logic [1:0] ACT_TX   = 2'd3;

    localparam logic [2:0] CFG_MSS   = 3'd0;
    localparam logic [2:0] CFG_USEC  = 3'd1;
    localparam logic [2:0] CFG_TPS   = 3'd2;
    localparam logic [2:0] CFG_AGING = 3'd3;
    localparam logic [2:0] CFG_INIT  = 3'd4;

    localparam logic [15:0] RST_MSS   = 16'd1460;
    localparam logic [19:0] RST_USEC  = 20'd1000;
    localparam logic [13:0] RST_TPS   = 14'd1000;
    localparam logic [30:0] RST_AGING = 31'd300000;
    localparam logic [19:0] RST_WIN   = 20'd10;

    localparam logic [19:0] MIN_WIN   = 20'd2;
    localparam logic [19:0] MIN_RTT   = 20'd1000;
    localparam logic [19:0] MAX_RTT   = 20'd1000000;
    localparam logic [31:0] BW_LIMIT  = 32'd250000000;
    localparam logic [15:0] SMALL_MSS = 16'd536;
    localparam logic [15:0] BIG_MSS   = 16'd1460;
    localparam logic [30:0] NO_LIMIT  = 31'h7fffffff;
    // ceil(2^35 / 10): x * this >> 35 is floor(x / 10) for any 32-bit x
    localparam logic [31:0] DIV10_MUL = 32'hcccccccd;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_RTT, OP_AGE_SET, OP_AGE_APPLY, OP_BW, OP_BW_APPLY,
        OP_MUL, OP_T_HALF, OP_Q1, OP_T_DIV, OP_GROW, OP_CAP, OP_LOSS, OP_TX, OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        DIV_BW, DIV_TICK, DIV_SEG
    } t_div_sel;

    typedef struct packed {
        t_op      op;
        logic     div_start;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       grow_go;
        logic       age_cond;
        logic       floor_nz;
        logic       bw_div;
        logic       bdp_fallback;
        logic       div_done;
    } t_stat;

endpackage

// File: rtl/tcpbdp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpbdp_div
// Restoring 32 by 32 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcpbdp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic [31:0] r_rem, r_quo, r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] shifted;
    logic [33:0] diff;
    logic        ge;

    always_comb begin
        shifted = {r_rem, r_quo[31]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        ge      = ~diff[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // keep the partial remainder below the divisor
                r_rem <= ge ? diff[31:0] : shifted[31:0];
                r_quo <= {r_quo[30:0], ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: rtl/tcpbdp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpbdp_dp
// Datapath: configuration, connection state, shared divider, result word.
// ----------------------------------------------------------------------------
module tcpbdp_dp #(
    parameter int MAX_WINDOW = 1000000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcpbdp_pkg::t_cmd   i_cmd,
    output tcpbdp_pkg::t_stat  o_stat,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_now_tick,
    input  logic [15:0]        i_pkts_acked,
    input  logic signed [31:0] i_rtt_sample_us,
    input  logic               i_cwnd_limited,
    output logic [19:0]        o_cwnd_out,
    output logic [30:0]        o_ssthresh_out,
    output logic [31:0]        o_bandwidth_est,
    output logic [19:0]        o_min_rtt_us
);
    import tcpbdp_pkg::*;

    localparam logic [19:0] MAXW = 20'(MAX_WINDOW);

    logic [15:0] r_mss;
    logic [19:0] r_usec;
    logic [13:0] r_tps;
    logic [30:0] r_aging;

    logic [1:0]  r_action;
    logic [31:0] r_now, r_rtt_raw, r_bytes;
    logic [15:0] r_acked;
    logic        r_limited;

    logic [31:0] r_last, r_sum, r_bw, r_age_start, r_q1;
    logic [19:0] r_floor, r_safe, r_window, r_t;
    logic [30:0] r_limit;
    logic [51:0] r_prod;

    logic [19:0] r_o_cwnd, r_o_rtt;
    logic [30:0] r_o_ss;
    logic [31:0] r_o_bw;

    logic [31:0] div_a, div_b, div_q;
    logic        div_done;

    function automatic logic [19:0] clamp_win(input logic [31:0] v);
        if (v < 32'(MIN_WIN))   return MIN_WIN;
        if (v > 32'(MAXW))      return MAXW;
        return v[19:0];
    endfunction

    function automatic logic [19:0] half_of(input logic [19:0] w);
        logic [19:0] h;
        h = w >> 1;
        return (h < MIN_WIN) ? MIN_WIN : h;
    endfunction

    // divide by ten with a reciprocal multiply
    function automatic logic [19:0] div_by_ten(input logic [22:0] x);
        logic [54:0] p;
        p = {32'b0, x} * {23'b0, DIV10_MUL};
        return p[54:35];
    endfunction

    logic        rtt_take;
    logic [19:0] rtt_c;
    logic [31:0] deadline, age_d;
    logic [20:0] grown;
    logic [31:0] delta, sum_sat;
    logic [32:0] sum_wide;
    logic [15:0] seg;
    logic [19:0] tick;
    logic [35:0] ewma;
    logic [20:0] w_new;
    logic [19:0] gap, safe_c, cap, v;

    always_comb begin
        rtt_take = (r_rtt_raw != 32'd0) && !r_rtt_raw[31];
        if (r_rtt_raw < 32'(MIN_RTT))      rtt_c = MIN_RTT;
        else if (r_rtt_raw > 32'(MAX_RTT)) rtt_c = MAX_RTT;
        else                               rtt_c = r_rtt_raw[19:0];
        deadline = r_age_start + {1'b0, r_aging};
        age_d    = r_now - deadline;
        grown    = {1'b0, r_floor} + {1'b0, div_by_ten({3'b0, r_floor})};
        delta    = r_now - r_last;
        sum_wide = {1'b0, r_sum} + {1'b0, r_bytes};
        sum_sat  = sum_wide[32] ? 32'hffffffff : sum_wide[31:0];
        seg      = (r_mss == 16'd0 || r_mss > BIG_MSS) ? SMALL_MSS : r_mss;
        tick     = (r_usec == 20'd0) ? 20'd1 : r_usec;
        ewma     = ({4'b0, r_bw} << 3) - {4'b0, r_bw} + {4'b0, div_q};
        safe_c   = clamp_win({12'b0, r_safe});
        // 80% of the window
        cap      = div_by_ten({r_window, 3'b000});
        v        = (r_t > cap) ? cap : r_t;
        if (v < MIN_WIN) v = MIN_WIN;
        // grow toward the target, then slow start, then by an eighth
        gap = '0;
        if (r_window < r_t) begin
            gap   = r_t - r_window;
            w_new = {1'b0, r_window} +
                    (({4'b0, r_acked} < gap) ? {5'b0, r_acked} : {1'b0, gap});
        end else if ({11'b0, r_window} <= r_limit) begin
            w_new = {1'b0, r_window} + {5'b0, r_acked};
        end else begin
            gap   = r_window >> 3;
            w_new = {1'b0, r_window} +
                    (({4'b0, r_acked} < gap) ? {5'b0, r_acked} : {1'b0, gap});
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_BW:   begin div_a = sum_sat;                   div_b = delta; end
            DIV_TICK: begin div_a = r_prod[31:0];              div_b = {12'b0, tick}; end
            DIV_SEG:  begin div_a = r_q1;                      div_b = {16'b0, seg}; end
            default:  begin div_a = r_q1;                      div_b = {16'b0, seg}; end
        endcase
    end

    tcpbdp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        o_stat.action       = r_action;
        o_stat.grow_go      = r_limited && (r_acked != 16'd0);
        o_stat.age_cond     = (age_d != 32'd0) && !age_d[31];
        o_stat.floor_nz     = (r_floor != 20'd0);
        o_stat.bw_div       = (r_last != 32'd0) && (delta != 32'd0) &&
                              (delta <= {18'b0, r_tps}) &&
                              (sum_sat > {15'b0, r_mss, 1'b0});
        o_stat.bdp_fallback = (r_bw == 32'd0) || (r_floor == 20'd0) ||
                              (r_prod[51:32] != 20'd0);
        o_stat.div_done     = div_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss       <= RST_MSS;
            r_usec      <= RST_USEC;
            r_tps       <= RST_TPS;
            r_aging     <= RST_AGING;
            r_last      <= '0;
            r_sum       <= '0;
            r_bw        <= '0;
            r_floor     <= '0;
            r_age_start <= '0;
            r_safe      <= RST_WIN;
            r_window    <= RST_WIN;
            r_limit     <= NO_LIMIT;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MSS:   r_mss   <= i_cfg_data[15:0];
                    CFG_USEC:  r_usec  <= i_cfg_data[19:0];
                    CFG_TPS:   r_tps   <= i_cfg_data[13:0];
                    CFG_AGING: r_aging <= i_cfg_data;
                    default:   ;  // an initial window write is ignored; reset loads RST_WIN
                endcase
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_action  <= i_action;
                    r_now     <= i_now_tick;
                    r_acked   <= i_pkts_acked;
                    r_rtt_raw <= i_rtt_sample_us;
                    r_limited <= i_cwnd_limited;
                    r_bytes   <= {16'b0, i_pkts_acked} * {16'b0, r_mss};
                end
                OP_RTT: begin
                    if (rtt_take && (r_floor == 20'd0 || rtt_c < r_floor)) begin
                        r_floor     <= rtt_c;
                        r_age_start <= r_now;
                    end
                end
                OP_AGE_SET: r_age_start <= r_now;
                OP_AGE_APPLY: begin
                    r_floor     <= (grown > {1'b0, MAX_RTT}) ? 20'd0 : grown[19:0];
                    r_age_start <= r_now;
                end
                OP_BW: begin
                    if (r_last == 32'd0) begin
                        r_last <= r_now;
                        r_sum  <= r_bytes;
                    end else if (delta > {18'b0, r_tps} && delta != 32'd0) begin
                        r_last <= r_now;
                        r_sum  <= '0;
                    end else begin
                        r_sum <= sum_sat;
                    end
                end
                OP_BW_APPLY: begin
                    if (div_q != 32'd0 && div_q < BW_LIMIT)
                        r_bw <= (r_bw == 32'd0) ? div_q : ewma[34:3];
                    r_sum  <= '0;
                    r_last <= r_now;
                end
                OP_MUL:    r_prod <= r_bw * r_floor;
                OP_T_HALF: begin
                    r_t    <= half_of(r_window);
                    r_safe <= half_of(r_window);
                end
                OP_Q1:     r_q1 <= div_q;
                OP_T_DIV: begin
                    r_t    <= clamp_win(div_q);
                    r_safe <= clamp_win(div_q);
                end
                OP_GROW:   r_window <= clamp_win({11'b0, w_new});
                OP_CAP:    r_limit  <= {11'b0, v};
                OP_LOSS: begin
                    r_bw        <= '0;
                    r_floor     <= '0;
                    r_sum       <= '0;
                    r_last      <= r_now;
                    r_age_start <= r_now;
                    r_window    <= safe_c;
                    r_limit     <= {11'b0, half_of(safe_c)};
                end
                OP_TX:     r_last <= r_now;
                OP_OUT: begin
                    r_o_cwnd <= r_window;
                    r_o_ss   <= r_limit;
                    r_o_bw   <= r_bw;
                    r_o_rtt  <= r_floor;
                end
                default: ;
            endcase
        end
    end

    assign o_cwnd_out      = r_o_cwnd;
    assign o_ssthresh_out  = r_o_ss;
    assign o_bandwidth_est = r_o_bw;
    assign o_min_rtt_us    = r_o_rtt;
endmodule

// File: rtl/tcpbdp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpbdp_ctrl
// Sequencer: steps one item through the datapath and hands off the result.
// ----------------------------------------------------------------------------
module tcpbdp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    output logic              o_valid,
    input  logic              i_ready,
    input  tcpbdp_pkg::t_stat i_stat,
    output tcpbdp_pkg::t_cmd  o_cmd
);
    import tcpbdp_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_RTT    = 13'b0000000000010,
        S_AGE    = 13'b0000000000100,
        S_BW     = 13'b0000000001000,
        S_BWW    = 13'b0000000010000,
        S_MUL    = 13'b0000000100000,
        S_BDPC   = 13'b0000001000000,
        S_D1     = 13'b0000010000000,
        S_D2S    = 13'b0000100000000,
        S_D2     = 13'b0001000000000,
        S_NEXT   = 13'b0010000000000,
        S_SIMPLE = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd.op         = OP_NONE;
        o_cmd.div_start  = 1'b0;
        o_cmd.div_sel    = DIV_BW;
        n_out_valid      = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    case (i_action)
                        ACT_ACK:  n_state = S_RTT;
                        ACT_CONG: n_state = S_MUL;
                        default:  n_state = S_SIMPLE;
                    endcase
                end
            end
            S_RTT: begin
                o_cmd.op = OP_RTT;
                n_state  = S_AGE;
            end
            S_AGE: begin
                n_state = S_BW;
                if (i_stat.age_cond) begin
                    o_cmd.op = i_stat.floor_nz ? OP_AGE_APPLY : OP_AGE_SET;
                end
            end
            S_BW: begin
                o_cmd.div_sel = DIV_BW;
                if (i_stat.bw_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_BWW;
                end else begin
                    o_cmd.op = OP_BW;
                    n_state  = i_stat.grow_go ? S_MUL : S_DONE;
                end
            end
            S_BWW: begin
                o_cmd.div_sel = DIV_BW;
                if (i_stat.div_done) begin
                    o_cmd.op = OP_BW_APPLY;
                    n_state  = i_stat.grow_go ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_BDPC;
            end
            S_BDPC: begin
                o_cmd.div_sel = DIV_TICK;
                if (i_stat.bdp_fallback) begin
                    o_cmd.op = OP_T_HALF;
                    n_state  = S_NEXT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_D1;
                end
            end
            S_D1: begin
                o_cmd.div_sel = DIV_TICK;
                if (i_stat.div_done) begin
                    o_cmd.op = OP_Q1;
                    n_state  = S_D2S;
                end
            end
            S_D2S: begin
                o_cmd.div_sel   = DIV_SEG;
                o_cmd.div_start = 1'b1;
                n_state         = S_D2;
            end
            S_D2: begin
                o_cmd.div_sel = DIV_SEG;
                if (i_stat.div_done) begin
                    o_cmd.op = OP_T_DIV;
                    n_state  = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.op = (i_stat.action == ACT_ACK) ? OP_GROW : OP_CAP;
                n_state  = S_DONE;
            end
            S_SIMPLE: begin
                o_cmd.op = (i_stat.action == ACT_LOSS) ? OP_LOSS : OP_TX;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // hold the finished word until the output register frees up
                if (!r_out_valid || i_ready) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
endmodule

// File: rtl/tcp_bdp_congestion_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_bdp_congestion_window
// Per-connection congestion window controller steered by bandwidth x min RTT.
// ----------------------------------------------------------------------------
// One item is in work at a time; every item yields one result word. Transmit
// start and loss need no division, and any result word may wait for the
// receiver. An ack and a congestion signal may use the shared 32-bit
// restoring divider: an ack for the bandwidth sample and two BDP divisions,
// a congestion signal for two BDP divisions. The tenth for RTT aging and
// the 80% cap come from a reciprocal multiply and add no wait. The result
// sits in an output register, so the next item is taken while the previous
// word waits. The configuration port is always ready and is to be written
// only while idle by the user; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tcp_bdp_congestion_window #(
    parameter int MAX_WINDOW = 1000000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_now_tick,
    input  logic [15:0]        i_pkts_acked,
    input  logic signed [31:0] i_rtt_sample_us,
    input  logic               i_cwnd_limited,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [19:0]        o_cwnd_out,
    output logic [30:0]        o_ssthresh_out,
    output logic [31:0]        o_bandwidth_est,
    output logic [19:0]        o_min_rtt_us
);
    import tcpbdp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // register writes always land, never stall them
    assign o_cfg_ready = 1'b1;

    // sequencer: walks the item through its steps
    tcpbdp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    // datapath: estimates, window, divider and the result word
    tcpbdp_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_now_tick      (i_now_tick),
        .i_pkts_acked    (i_pkts_acked),
        .i_rtt_sample_us (i_rtt_sample_us),
        .i_cwnd_limited  (i_cwnd_limited),
        .o_cwnd_out      (o_cwnd_out),
        .o_ssthresh_out  (o_ssthresh_out),
        .o_bandwidth_est (o_bandwidth_est),
        .o_min_rtt_us    (o_min_rtt_us)
    );

    // the window handed out always stays inside its clamp
    a_cwnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cwnd_out >= 20'd2 && o_cwnd_out <= 20'(MAX_WINDOW)))
        else $error("cwnd out of range");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item accepted while busy");

    // the RTT floor never passes its ceiling
    a_rtt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_min_rtt_us <= 20'd1000000))
        else $error("min rtt out of range");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BDP congestion window controller.
// ----------------------------------------------------------------------------
// A behavioral predictor in this file follows every accepted item and pushes
// the expected result word onto a queue. A monitor compares each word the
// block hands out with the oldest prediction. The stimulus starts with
// directed items, then runs ack sequences with random content under four
// idling phases, then a backpressure test, and finishes with four register settings, extremes among them.
// ----------------------------------------------------------------------------
module tb;
    import tcpbdp_pkg::*;

    localparam int WIN_MAX = 1000000;

    typedef struct packed {
        logic [19:0] cwnd;
        logic [30:0] ssthresh;
        logic [31:0] bw;
        logic [19:0] rtt;
    } t_word;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         in_action;
    logic [31:0]        in_now;
    logic [15:0]        in_acked;
    logic signed [31:0] in_rtt;
    logic               in_limited;
    logic               out_valid;
    logic               out_ready;
    logic [19:0]        out_cwnd;
    logic [30:0]        out_ssthresh;
    logic [31:0]        out_bw;
    logic [19:0]        out_rtt;

    // Register and state copies held by the predictor.
    logic [31:0] r_mss, r_usec, r_tps, r_aging;
    logic [31:0] s_last_ack, s_byte_sum, s_bw, s_floor;
    logic [31:0] s_safe, s_age_start, s_win, s_ssthresh;

    t_word       pending_words[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    logic [31:0] tick;

    tcp_bdp_congestion_window dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_action(in_action), .i_now_tick(in_now), .i_pkts_acked(in_acked),
        .i_rtt_sample_us(in_rtt), .i_cwnd_limited(in_limited),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_cwnd_out(out_cwnd), .o_ssthresh_out(out_ssthresh),
        .o_bandwidth_est(out_bw), .o_min_rtt_us(out_rtt)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] clamp_window(logic [31:0] v);
        if (v < 2) return 2;
        if (v > WIN_MAX) return WIN_MAX;
        return v;
    endfunction

    function automatic logic [31:0] half_of_window();
        logic [31:0] h;
        h = s_win >> 1;
        return (h < 2) ? 32'd2 : h;
    endfunction

    // Target window from bandwidth x min RTT; also updates the safe window.
    function automatic logic [31:0] bdp_window();
        logic [31:0] seg, tk, t;
        logic [63:0] prod;
        seg = r_mss;
        tk = (r_usec != 0) ? r_usec : 32'd1;
        if (seg == 0 || seg > BIG_MSS) seg = SMALL_MSS;
        if (s_bw == 0 || s_floor == 0 || s_bw > 32'hffffffff / s_floor) begin
            t = half_of_window();
        end else begin
            prod = 64'(s_bw) * 64'(s_floor);
            prod = prod / tk;
            prod = prod / seg;
            t = (prod > 64'hffffffff) ? 32'hffffffff : prod[31:0];
            t = clamp_window(t);
        end
        s_safe = t;
        return t;
    endfunction

    function automatic void track_rtt(logic [31:0] now, logic [31:0] raw);
        logic [31:0] r, d, grown;
        if (raw != 0 && !raw[31]) begin
            r = raw;
            if (r < MIN_RTT) r = MIN_RTT;
            if (r > MAX_RTT) r = MAX_RTT;
            if (s_floor == 0 || r < s_floor) begin
                s_floor = r;
                s_age_start = now;
            end
        end
        d = now - (s_age_start + r_aging);
        if (d != 0 && !d[31]) begin
            if (s_floor > 0) begin
                grown = s_floor + s_floor / 10;
                s_floor = (grown > MAX_RTT) ? 32'd0 : grown;
            end
            s_age_start = now;
        end
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hffffffff : s[31:0];
    endfunction

    function automatic void track_bandwidth(logic [31:0] now, logic [31:0] bytes);
        logic [31:0] delta, cur;
        logic [63:0] mix;
        if (s_last_ack == 0) begin
            s_last_ack = now;
            s_byte_sum = bytes;
            return;
        end
        delta = now - s_last_ack;
        if (delta == 0) begin
            s_byte_sum = add_sat(s_byte_sum, bytes);
            return;
        end
        if (delta > r_tps) begin
            s_last_ack = now;
            s_byte_sum = 0;
            return;
        end
        s_byte_sum = add_sat(s_byte_sum, bytes);
        if (s_byte_sum > (r_mss << 1)) begin
            cur = s_byte_sum / delta;
            if (cur > 0 && cur < BW_LIMIT) begin
                if (s_bw == 0) begin
                    s_bw = cur;
                end else begin
                    mix = (64'(s_bw) * 7 + 64'(cur)) / 8;
                    s_bw = mix[31:0];
                end
            end
            s_byte_sum = 0;
            s_last_ack = now;
        end
    endfunction

    function automatic void grow_cwnd(logic [31:0] acked, logic limited);
        logic [31:0] target, gap, w;
        w = s_win;
        if (!limited || acked == 0) return;
        target = bdp_window();
        if (w < target) begin
            gap = target - w;
            w += (acked < gap) ? acked : gap;
        end else if (w <= s_ssthresh) begin
            w += acked;
        end else begin
            gap = w >> 3;
            w += (acked < gap) ? acked : gap;
        end
        s_win = clamp_window(w);
    endfunction

    function automatic t_word predict_word(logic [1:0] act, logic [31:0] now,
                                           logic [15:0] acked, logic [31:0] raw,
                                           logic limited);
        logic [31:0] v, cap;
        t_word w;
        case (act)
            ACT_ACK: begin
                track_rtt(now, raw);
                track_bandwidth(now, 32'(acked) * r_mss);
                grow_cwnd(32'(acked), limited);
            end
            ACT_CONG: begin
                v = bdp_window();
                if (v < 2) v = 2;
                cap = (s_win * 8) / 10;
                if (v > cap) v = cap;
                if (v < 2) v = 2;
                s_ssthresh = v & 32'h7fffffff;
            end
            ACT_LOSS: begin
                s_bw = 0;
                s_floor = 0;
                s_byte_sum = 0;
                s_last_ack = now;
                s_age_start = now;
                s_win = clamp_window(s_safe);
                s_ssthresh = half_of_window();
            end
            default: begin
                s_last_ack = now;
            end
        endcase
        w.cwnd = s_win[19:0];
        w.ssthresh = s_ssthresh[30:0];
        w.bw = s_bw;
        w.rtt = s_floor[19:0];
        return w;
    endfunction

    // ------------------------------------------------------------ drivers

    // Offer one word, hold it until accepted, then predict it.
    task automatic send_item(logic [1:0] act, logic [31:0] now, logic [15:0] acked,
                             logic [31:0] raw, logic limited);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_action <= act;
        in_now <= now;
        in_acked <= acked;
        in_rtt <= raw;
        in_limited <= limited;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_words.push_back(predict_word(act, now, acked, raw, limited));
    endtask

    // Wait for every expected word, then let the block settle.
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_words.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[30:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_MSS:   r_mss = value & 32'hffff;
            CFG_USEC:  r_usec = value & 32'hfffff;
            CFG_TPS:   r_tps = value & 32'h3fff;
            CFG_AGING: r_aging = value & 32'h7fffffff;
            CFG_INIT:  ;  // an initial window write is ignored; reset loads RST_WIN
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_rtt();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'(-$urandom_range(1000, 1));
            2: return 0;
            3: return $urandom_range(999);
            4: return $urandom_range(2000000, 900000);
            default: return $urandom_range(300000, 5000);
        endcase
    endfunction

    // ------------------------------------------------------------ monitor

    always @(posedge clk) begin
        t_word w;
        if (rst_n) begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct) && hold_off_cycles == 0;
            if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
            if (out_valid && out_ready) begin
                if (pending_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word at %0t", $realtime);
                end else begin
                    w = pending_words.pop_front();
                    if (w !== {out_cwnd, out_ssthresh, out_bw, out_rtt}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: cwnd %0d/%0d ssth %0d/%0d bw %0d/%0d rtt %0d/%0d",
                                     w.cwnd, out_cwnd, w.ssthresh, out_ssthresh,
                                     w.bw, out_bw, w.rtt, out_rtt);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------ tests

    task automatic test_directed();
        send_item(ACT_ACK, 32'd100, 16'd0, 32'hffffffff, 1'b1);
        send_item(ACT_ACK, 32'd100, 16'd5, 32'd500, 1'b1);
        send_item(ACT_ACK, 32'd101, 16'd10, 32'd30000, 1'b1);
        send_item(ACT_ACK, 32'd102, 16'hffff, 32'h7fffffff, 1'b1);
        send_item(ACT_ACK, 32'd103, 16'd20, 32'd20000, 1'b0);
        send_item(ACT_ACK, 32'd104, 16'd20, 32'h80000000, 1'b1);
        send_item(ACT_CONG, 32'd105, 16'd0, 32'd0, 1'b0);
        send_item(ACT_ACK, 32'd3000, 16'd3, 32'd20000, 1'b1);
        send_item(ACT_TX, 32'hffffffff, 16'd0, 32'd0, 1'b1);
        send_item(ACT_ACK, 32'd5, 16'd4, 32'd20000, 1'b1);
        send_item(ACT_ACK, 32'd400000, 16'd4, 32'd999999, 1'b1);
        send_item(ACT_LOSS, 32'd400001, 16'd0, 32'd0, 1'b0);
        send_item(ACT_CONG, 32'd400002, 16'hffff, 32'hffffffff, 1'b1);
        send_item(ACT_ACK, 32'd0, 16'd1, 32'd1, 1'b1);
        drain();
    endtask

    // One ack run: mostly steady ticks, mostly sane RTTs, occasional other actions.
    task automatic ack_burst(int count);
        logic [1:0] act;
        for (int i = 0; i < count; i++) begin
            tick += $urandom_range(3);
            if ($urandom_range(99) < 3) tick += $urandom_range(20000);
            act = ($urandom_range(99) < 85) ? ACT_ACK : 2'($urandom_range(3));
            send_item(act, tick, ($urandom_range(9) == 0) ? 16'($urandom) :
                      16'($urandom_range(40)), rand_rtt(), $urandom_range(9) != 0);
        end
    endtask

    task automatic test_random_phases();
        int pct[4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{33, 33}};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = pct[p][0];
            recv_stall_pct = pct[p][1];
            ack_burst(400);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
    endtask

    // Hold the receiver off so the block backs up, then pause the sender.
    task automatic test_backpressure();
        hold_off_cycles = 2000;
        ack_burst(40);
        drain();
        ack_burst(20);
        drain();
    endtask

    task automatic test_register_settings();
        logic [31:0] sets[4][5] = '{
            '{32'd1, 32'd1, 32'd1, 32'd1, 32'd2},
            '{32'd65535, 32'd1000000, 32'd10000, 32'h7fffffff, 32'd1000000},
            '{32'd536, 32'd10, 32'd500, 32'd5000, 32'd40},
            '{32'd1460, 32'd1000, 32'd1000, 32'd300000, 32'd10}};
        for (int s = 0; s < 4; s++) begin
            for (int r = 0; r < 5; r++) write_reg(3'(r), sets[s][r]);
            cfg_valid <= 1'b0;
            send_idle_pct = 20;
            recv_stall_pct = 20;
            ack_burst(90);
            drain();
        end
        // Fully random values on every input bit.
        for (int i = 0; i < 20; i++)
            send_item(2'($urandom), $urandom, 16'($urandom), $urandom, 1'($urandom));
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_action = ACT_ACK;
        in_now = '0;
        in_acked = '0;
        in_rtt = '0;
        in_limited = 1'b0;
        out_ready = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        tick = 32'd1000;
        r_mss = RST_MSS;
        r_usec = RST_USEC;
        r_tps = RST_TPS;
        r_aging = RST_AGING;
        s_last_ack = 0;
        s_byte_sum = 0;
        s_bw = 0;
        s_floor = 0;
        s_age_start = 0;
        s_win = RST_WIN;
        s_safe = RST_WIN;
        s_ssthresh = 32'h7fffffff;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        test_register_settings();
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("simulation failed");
        $finish;
    end

endmodule
